[rtl/ppu_vram_data_port_unit_defines.svh]
// Assertion macros for the video-memory data port.
`ifndef PPU_VRAM_DATA_PORT_UNIT_DEFINES_SVH
`define PPU_VRAM_DATA_PORT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define VDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define VDP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define VDP_ASSERT(lbl, prop, msg)
`define VDP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/ppu_vdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ppu_vdp_pkg;

    localparam int NAME_TABLE_BYTES = 1024;
    localparam int CHARACTER_BYTES  = 8192;
    localparam int PALETTE_BYTES    = 32;

    localparam int ADDR_W = 14;
    localparam int DATA_W = 8;
    localparam int NT_IDX_W  = $clog2(2 * NAME_TABLE_BYTES);
    localparam int CHR_IDX_W = $clog2(CHARACTER_BYTES);
    localparam int PAL_IDX_W = $clog2(PALETTE_BYTES);

    localparam logic [5:0] PAL_REGION_HI = 6'h3F;   // address bits 13..8 of palette space

    typedef enum logic [1:0] {
        OP_LOAD_ADDR = 2'd0,
        OP_READ      = 2'd1,
        OP_WRITE     = 2'd2
    } vdp_op_t;

    typedef enum logic [1:0] {
        MIRROR_VERTICAL   = 2'd0,
        MIRROR_HORIZONTAL = 2'd1
    } vdp_mirror_t;

    localparam logic REG_INCREMENT = 1'b0;
    localparam logic REG_MIRROR    = 1'b1;

    function automatic logic [NT_IDX_W-1:0] nt_index(input logic [ADDR_W-1:0] a,
                                                    input logic [1:0] mode);
        logic tbl;
        tbl = 1'b0;
        unique case (mode)
            MIRROR_VERTICAL:   tbl = a[10];
            MIRROR_HORIZONTAL: tbl = a[11];
            default:           tbl = 1'b0;
        endcase
        return {tbl, a[NT_IDX_W-2:0]};
    endfunction

    // sprite entries 0x10/0x14/0x18/0x1C alias background entries
    function automatic logic [PAL_IDX_W-1:0] pal_index(input logic [ADDR_W-1:0] a);
        logic [PAL_IDX_W-1:0] i;
        i = a[PAL_IDX_W-1:0];
        if (i[4] && (i[1:0] == 2'b00)) begin
            i[4] = 1'b0;
        end
        return i;
    endfunction

endpackage

`default_nettype wire

[rtl/ppu_vram_data_port_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Results are registered and leave on m_* in the cycle after accept on s_*.
// Throughput: one word per cycle while m_ready keeps up; non-palette reads and
// writes hit the synchronous character/name-table RAMs at accept, the refilled
// read buffer is forwarded. Reset (aresetn low, synchronous) clears control and
// palette registers, then zeroes the name-table RAM one byte a cycle, s_ready low.

`include "ppu_vram_data_port_unit_defines.svh"

module ppu_vram_data_port_unit
    import ppu_vdp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input words
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_operation,
    input  wire logic [ADDR_W-1:0] s_address,
    input  wire logic [DATA_W-1:0] s_write_data,
    // result words
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_read_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       inc32_reg;
    logic [1:0] mirror_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc32_reg  <= 1'b0;
            mirror_reg <= 2'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_INCREMENT) begin
                inc32_reg <= pwdata[0];
            end else begin
                mirror_reg <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_INCREMENT) begin
            prdata[0] = inc32_reg;
        end else begin
            prdata[1:0] = mirror_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic                clearing_reg, clearing_next;
    logic [NT_IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]   rbuf_reg, rbuf_next;
    logic                refill_reg, refill_next;     // buffer refill due from RAM q
    logic                refill_nt_reg, refill_nt_next; // refill source: name table
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;

    // memories
    logic [DATA_W-1:0] chr_mem [CHARACTER_BYTES];
    logic [DATA_W-1:0] nt_mem  [2 * NAME_TABLE_BYTES];
    logic [DATA_W-1:0] pal_reg [PALETTE_BYTES];
    logic [DATA_W-1:0] chr_q_reg;
    logic [DATA_W-1:0] nt_q_reg;

    // access decode
    logic                 accept;
    logic                 is_pat, is_pal;
    logic [ADDR_W-1:0]    step_sum;
    logic [NT_IDX_W-1:0]  nt_idx;
    logic [PAL_IDX_W-1:0] pal_idx;
    logic [DATA_W-1:0]    buf_now;
    logic                 do_read, do_write;
    logic                 buffered_rd;

    assign s_ready = !clearing_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    assign is_pat   = !addr_reg[ADDR_W-1];
    assign is_pal   = (addr_reg[ADDR_W-1:8] == PAL_REGION_HI);
    assign step_sum = addr_reg + (inc32_reg ? ADDR_W'(32) : ADDR_W'(1));
    assign nt_idx   = nt_index(addr_reg, mirror_reg);
    assign pal_idx  = pal_index(addr_reg);

    assign do_read     = accept && (s_operation == OP_READ);
    assign do_write    = accept && (s_operation == OP_WRITE);
    assign buffered_rd = do_read && !is_pal;

    // buffer as seen now: a refill started last cycle is taken straight from RAM q
    assign buf_now = refill_reg ? (refill_nt_reg ? nt_q_reg : chr_q_reg) : rbuf_reg;

    always_comb begin
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        rbuf_next      = buf_now;
        refill_next    = buffered_rd;
        refill_nt_next = !is_pat;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + NT_IDX_W'(1);
            if (&clr_cnt_reg) begin
                clearing_next = 1'b0;
            end
        end

        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            case (s_operation)
                OP_LOAD_ADDR: addr_next = s_address;
                OP_READ: begin
                    addr_next   = step_sum;
                    m_data_next = is_pal ? pal_reg[pal_idx] : buf_now;
                end
                OP_WRITE: addr_next = step_sum;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            addr_reg      <= '0;
            rbuf_reg      <= '0;
            refill_reg    <= 1'b0;
            refill_nt_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            addr_reg      <= addr_next;
            rbuf_reg      <= rbuf_next;
            refill_reg    <= refill_next;
            refill_nt_reg <= refill_nt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // character RAM: contents undefined until written
    always_ff @(posedge aclk) begin
        if (do_write && is_pat) begin
            chr_mem[addr_reg[CHR_IDX_W-1:0]] <= s_write_data;
        end
        if (do_read && is_pat) begin
            chr_q_reg <= chr_mem[addr_reg[CHR_IDX_W-1:0]];
        end
    end

    // name-table RAM: zeroed by the clearing pass after reset
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            nt_mem[clr_cnt_reg] <= '0;
        end else if (do_write && !is_pat && !is_pal) begin
            nt_mem[nt_idx] <= s_write_data;
        end
        if (do_read && !is_pat && !is_pal) begin
            nt_q_reg <= nt_mem[nt_idx];
        end
    end

    // palette: small register file, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_BYTES; i++) begin
                pal_reg[i] <= '0;
            end
        end else if (do_write && is_pal) begin
            pal_reg[pal_idx] <= s_write_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VDP_ASSERT(a_no_accept_clearing, clearing_reg |-> !s_ready, "word accepted during clear")
    `VDP_ASSERT(a_refill_follows_read, buffered_rd |=> refill_reg, "buffer refill not scheduled")
    `VDP_ASSERT(a_addr_step, (do_read || do_write) |=> (addr_reg == $past(step_sum)), "address step wrong")
    `VDP_ASSERT(a_result_after_accept, accept |=> m_valid_reg, "result missing after accept")
    `VDP_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (clearing_reg && !m_valid_reg), "reset state wrong")

endmodule

`default_nettype wire

[verif/ppu_vram_data_port_unit_test.sv]
`timescale 1ns / 1ps

module ppu_vram_data_port_unit_test;
    import ppu_vdp_pkg::*;

    // ---------------------------------------------------------------------
    // Local codes and limits
    // ---------------------------------------------------------------------
    localparam logic [1:0] OP_IGNORED    = 2'd3;   // unused opcode, no effect
    localparam logic [1:0] MIRROR_SINGLE = 2'd2;   // every name-table access hits table 0

    localparam logic [2:0] INCR_REG_ADDR   = {REG_INCREMENT, 2'b00};
    localparam logic [2:0] MIRROR_REG_ADDR = {REG_MIRROR, 2'b00};

    localparam logic [ADDR_W-1:0] NT_BASE  = 14'h2000;   // start of name-table space
    localparam logic [ADDR_W-1:0] PAL_BASE = 14'h3F00;   // start of palette space

    localparam int PHASE_WORDS = 150;        // random words per configuration phase
    localparam int NUM_PHASES  = 6;
    localparam int LONG_HOLD   = 300;        // one long receiver stall, in cycles
    localparam int CYCLE_LIMIT = 1000000;

    // ---------------------------------------------------------------------
    // Shadow of the data port: address register, read buffer, memories
    // ---------------------------------------------------------------------
    class vram_shadow;
        bit                incr32;
        logic [1:0]        mirror;
        logic [ADDR_W-1:0] vaddr;
        logic [7:0]        rbuf;
        logic [7:0]        nt_mem  [0:2*NAME_TABLE_BYTES-1];
        logic [7:0]        pal_mem [0:PALETTE_BYTES-1];
        logic [7:0]        chr_mem [0:CHARACTER_BYTES-1];
        bit                chr_written [0:CHARACTER_BYTES-1];
        logic [7:0]        read_data_q [$];
        int                errors;

        function new();
            incr32 = 1'b0;
            mirror = MIRROR_VERTICAL;
            vaddr  = '0;
            rbuf   = '0;
            foreach (nt_mem[i]) nt_mem[i] = '0;
            foreach (pal_mem[i]) pal_mem[i] = '0;
            foreach (chr_mem[i]) begin
                chr_mem[i]     = '0;
                chr_written[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return read_data_q.size();
        endfunction

        // pattern-region read at the current address would touch an unwritten byte
        function bit next_read_undefined();
            return (vaddr < NT_BASE) && !chr_written[vaddr[12:0]];
        endfunction

        function logic [10:0] table_slot(logic [ADDR_W-1:0] a);
            logic sel;
            case (mirror)
                MIRROR_VERTICAL:   sel = a[10];
                MIRROR_HORIZONTAL: sel = a[11];
                default:           sel = 1'b0;
            endcase
            return {sel, a[9:0]};
        endfunction

        // sprite entries whose low two bits are zero fold onto background entries
        function logic [4:0] palette_slot(logic [ADDR_W-1:0] a);
            return (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
        endfunction

        function logic [ADDR_W-1:0] take_address();
            logic [ADDR_W-1:0] a;
            a     = vaddr;
            vaddr = a + (incr32 ? 14'd32 : 14'd1);
            return a;
        endfunction

        function void predict_word(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [7:0] wdata);
            logic [ADDR_W-1:0] a;
            logic [7:0]        rd;
            rd = 8'h00;
            case (op)
                OP_LOAD_ADDR: vaddr = addr;
                OP_READ: begin
                    a = take_address();
                    if (a < NT_BASE) begin
                        rd   = rbuf;
                        rbuf = chr_mem[a[12:0]];
                    end else if (a < PAL_BASE) begin
                        rd   = rbuf;
                        rbuf = nt_mem[table_slot(a)];
                    end else begin
                        rd = pal_mem[palette_slot(a)];
                    end
                end
                OP_WRITE: begin
                    a = take_address();
                    if (a < NT_BASE) begin
                        chr_mem[a[12:0]]     = wdata;
                        chr_written[a[12:0]] = 1'b1;
                    end else if (a < PAL_BASE) begin
                        nt_mem[table_slot(a)] = wdata;
                    end else begin
                        pal_mem[palette_slot(a)] = wdata;
                    end
                end
                default: ;
            endcase
            read_data_q.push_back(rd);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_read_data(logic [7:0] got);
            logic [7:0] want;
            if (read_data_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word, read_data=%02h", got));
            end else begin
                want = read_data_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("read_data got %02h want %02h", got, want));
            end
        endtask
    endclass

    // ---------------------------------------------------------------------
    // Signals
    // ---------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_operation;
    logic [ADDR_W-1:0] s_address;
    logic [DATA_W-1:0] s_write_data;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_read_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    vram_shadow sb;
    int         result_count = 0;
    int         cycle_count;
    bit         long_hold_done = 1'b0;

    ppu_vram_data_port_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Monitors: inputs are noted before the result check so that a word and
    // its own result on the same edge would still line up.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.predict_word(s_operation, s_address, s_write_data);
            if (m_valid && m_ready) begin
                sb.check_read_data(m_read_data);
                result_count++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // One word on s_*; after acceptance it may drop s_valid and idle for a random gap
    // (never when told not to), then returns at a falling edge; else s_valid stays high.
    task automatic issue_word(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [7:0] wdata, input bit gapless);
        int roll;
        int gap;
        // never let a read pull a character byte that was never stored
        if (op == OP_READ && sb.next_read_undefined())
            op = OP_WRITE;
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_address    <= addr;
        s_write_data <= wdata;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        roll = $urandom_range(0, 99);
        if (gapless || roll < 60)
            gap = 0;
        else if (roll < 88)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            s_valid      <= 1'b0;
            s_address    <= ADDR_W'($urandom_range(0, 16383));
            s_write_data <= DATA_W'($urandom_range(0, 255));
            repeat (gap) @(negedge aclk);
        end
    endtask

    // drop valid, wait for every expected word, then wait out a margin
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one APB transfer: setup, access, then idle with psel low
    task automatic apb_access(input bit is_write, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // write both registers while idle and read them back
    task automatic configure(input bit incr, input logic [1:0] mode);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, INCR_REG_ADDR, {31'b0, incr}, rd);
        apb_access(1'b0, INCR_REG_ADDR, '0, rd);
        if (rd !== {31'b0, incr})
            sb.report_mismatch($sformatf("increment reg reads %08h", rd));
        apb_access(1'b1, MIRROR_REG_ADDR, {30'b0, mode}, rd);
        apb_access(1'b0, MIRROR_REG_ADDR, '0, rd);
        if (rd !== {30'b0, mode})
            sb.report_mismatch($sformatf("mirror reg reads %08h", rd));
        sb.incr32 = incr;
        sb.mirror = mode;
    endtask

    // Addresses cluster in small windows so that reads revisit written bytes
    // and name-table aliases collide.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [3:0] hi;
        logic [9:0] lo;
        case ($urandom_range(0, 2))
            0: return $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 127))
                                           : ADDR_W'($urandom_range(14'h1F80, 14'h1FFF));
            1: begin
                hi = 4'($urandom_range(8, 15));
                lo = $urandom_range(0, 1) ? 10'($urandom_range(0, 31))
                                          : 10'($urandom_range(992, 1023));
                return {hi, lo};
            end
            default: return PAL_BASE | ADDR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_words(input int count);
        int  sent;
        int  roll;
        int  len;
        bit  gapless;
        sent = 0;
        while (sent < count) begin
            roll    = $urandom_range(0, 99);
            len     = $urandom_range(1, 8);
            gapless = ($urandom_range(0, 3) == 0);
            if (roll < 35) begin
                // fill burst
                issue_word(OP_LOAD_ADDR, pick_address(), 8'($urandom_range(0, 255)), gapless);
                repeat (len) issue_word(OP_WRITE, ADDR_W'($urandom_range(0, 16383)),
                                        8'($urandom_range(0, 255)), gapless);
                sent += len + 1;
            end else if (roll < 75) begin
                // read-back burst
                issue_word(OP_LOAD_ADDR, pick_address(), 8'($urandom_range(0, 255)), gapless);
                repeat (len) issue_word(OP_READ, ADDR_W'($urandom_range(0, 16383)),
                                        8'($urandom_range(0, 255)), gapless);
                sent += len + 1;
            end else if (roll < 85) begin
                // reads and writes mixed, continuing from wherever the address is
                repeat (len) issue_word($urandom_range(1, 2) == 1 ? OP_READ : OP_WRITE,
                                        ADDR_W'($urandom_range(0, 16383)),
                                        8'($urandom_range(0, 255)), gapless);
                sent += len;
            end else begin
                // noise: any opcode, any address
                len = $urandom_range(1, 3);
                repeat (len) issue_word(2'($urandom_range(0, 3)),
                                        ADDR_W'($urandom_range(0, 16383)),
                                        8'($urandom_range(0, 255)), gapless);
                sent += len;
            end
        end
    endtask

    // Hand-picked words under reset settings (step 1, vertical mirroring).
    task automatic directed_words();
        // pattern bytes at the bottom of the space, extremes of write data
        issue_word(OP_LOAD_ADDR, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'hFF, 1'b0);
        // buffered reads: first returns the reset buffer, second the byte at 0
        issue_word(OP_LOAD_ADDR, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        // name table straight after reset is zero
        issue_word(OP_LOAD_ADDR, 14'h2400, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        // 0x2C05 and the 0x3405 mirror both land in table 1 under vertical
        issue_word(OP_LOAD_ADDR, 14'h2C05, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'h11, 1'b0);
        issue_word(OP_LOAD_ADDR, 14'h3405, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        // sprite palette entries alias background entries
        issue_word(OP_LOAD_ADDR, 14'h3F10, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'hAA, 1'b0);
        issue_word(OP_LOAD_ADDR, 14'h3F1C, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'h5A, 1'b0);
        issue_word(OP_LOAD_ADDR, 14'h3F00, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_LOAD_ADDR, 14'h3F0C, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        // top address: write and unbuffered read, then the step wraps to 0
        issue_word(OP_LOAD_ADDR, 14'h3FFF, 8'h00, 1'b0);
        issue_word(OP_WRITE, 14'h0000, 8'hC3, 1'b0);
        issue_word(OP_LOAD_ADDR, 14'h3FFF, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        issue_word(OP_READ, 14'h0000, 8'h00, 1'b0);
        // unused opcode with every field bit set: no state change
        issue_word(OP_IGNORED, 14'h3FFF, 8'hFF, 1'b0);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        bit         phase_incr [NUM_PHASES];
        logic [1:0] phase_mode [NUM_PHASES];
        phase_incr   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        phase_mode   = '{MIRROR_VERTICAL, MIRROR_HORIZONTAL,
                         MIRROR_SINGLE, MIRROR_VERTICAL,
                         MIRROR_SINGLE, MIRROR_HORIZONTAL};
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_LOAD_ADDR;
        s_address    = '0;
        s_write_data = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // name-table clearing pass holds s_ready low; the handshake waits it out
        directed_words();

        // each phase starts idle, which also covers the full sender pause
        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(phase_incr[p], phase_mode[p]);
            random_words(PHASE_WORDS);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: ready runs and stalls of random length; once, mid-run, a long
    // hold while the sender is busy so the block backs up into s_ready.
    // ---------------------------------------------------------------------
    initial begin
        int roll;
        int ready_len;
        int stall_len;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            roll      = $urandom_range(0, 99);
            ready_len = (roll < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (ready_len) @(negedge aclk);
            roll = $urandom_range(0, 99);
            if (!long_hold_done && result_count >= 200 && s_valid) begin
                stall_len      = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (roll < 70) begin
                stall_len = $urandom_range(1, 3);
            end else if (roll < 95) begin
                stall_len = $urandom_range(4, 15);
            end else begin
                stall_len = $urandom_range(30, 80);
            end
            m_ready <= 1'b0;
            repeat (stall_len) @(negedge aclk);
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
